FILE: rtl/kcl_pkg.sv
`default_nettype none
package kcl_pkg;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int NUM_CHAN = 9;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_LOOP = 2'd1;
    localparam logic [1:0] CFG_KEYS = 2'd2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_DISPATCH,
        ST_SEARCH,
        ST_FETCH,
        ST_LATCH,
        ST_CHAN,
        ST_DIV,
        ST_STORE,
        ST_EMIT,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic load_table;
        logic start_mod;
        logic clear_search;
        logic step_search;
        logic fetch_manual;
        logic fetch_seg;
        logic latch_seg;
        logic prep_chan;
        logic store_chan;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic mod_done;
        logic manual;
        logic search_done;
        logic div_done;
        logic last_chan;
        logic out_busy;
    } status_t;
endpackage
`default_nettype wire

FILE: rtl/keyframe_color_lerp.sv
// Keyframe color animation unit.
// Input channel s_*: an action of load writes one table entry (key time,
// primary RGBA+LOD, environment RGBA) and produces no result. A tick
// reduces s_frame_value modulo loop_length and gives one m_* transaction.
// Manual mode looks the reduced frame up directly; linear mode searches
// the keys and blends the nine channels with an exact signed division.
// A load is written while idle. A tick runs the restoring modulo, a
// dispatch, then in linear mode a search that reads and compares one key
// at a time and a fetch of the segment, then one restoring division per
// channel for the nine channels on a shared divider. The modulo and the
// divider both work one bit a cycle, and one tick is processed at a time;
// the next transaction is taken once the block is back in its idle state.
// The result register holds its transaction while m_ready is low; the
// next tick finishes its work and waits only at the final handoff.
// Reset restores interp_mode 1, loop_length 1, key_total 2 and drops any
// pending result. The table is undefined until written.
// Config writes (cfg_we, cfg_index, cfg_data) are to be made only while idle; the block itself does not enforce this.
`default_nettype none
module keyframe_color_lerp #(
    parameter int TABLE_DEPTH = kcl_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [3:0]  s_entry_index,
    input  wire logic [31:0] s_frame_value,
    input  wire logic [31:0] s_prim_rgba,
    input  wire logic [7:0]  s_prim_lod,
    input  wire logic [31:0] s_env_rgba,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_prim_red,
    output logic [7:0]       m_prim_green,
    output logic [7:0]       m_prim_blue,
    output logic [7:0]       m_prim_alpha,
    output logic [7:0]       m_prim_level,
    output logic [7:0]       m_env_red,
    output logic [7:0]       m_env_green,
    output logic [7:0]       m_env_blue,
    output logic [7:0]       m_env_alpha,
    output logic             m_index_error
);
    import kcl_pkg::*;

    cmd_t        cmd;
    status_t     sts;
    logic [71:0] chan;

    kcl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_action(s_action),
        .in_ready(s_ready), .sts(sts), .cmd(cmd)
    );

    kcl_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_entry(s_entry_index), .in_frame(s_frame_value),
        .in_prim(s_prim_rgba), .in_lod(s_prim_lod), .in_env(s_env_rgba),
        .cmd(cmd), .sts(sts), .out_valid(m_valid), .out_ready(m_ready),
        .out_chan(chan), .out_err(m_index_error)
    );

    assign {m_prim_red, m_prim_green, m_prim_blue, m_prim_alpha, m_prim_level,
            m_env_red, m_env_green, m_env_blue, m_env_alpha} = chan;
endmodule
`default_nettype wire

FILE: rtl/kcl_ctrl.sv
`default_nettype none
module kcl_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    input  wire logic            in_action,
    output logic                 in_ready,
    input  wire kcl_pkg::status_t sts,
    output kcl_pkg::cmd_t        cmd
);
    import kcl_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_action == ACT_TICK) state_next = ST_MOD;
            end
            ST_MOD:      if (sts.mod_done) state_next = ST_DISPATCH;
            ST_DISPATCH: state_next = sts.manual ? ST_LATCH : ST_SEARCH;
            ST_SEARCH:   if (sts.search_done) state_next = ST_FETCH;
            ST_FETCH:    state_next = ST_LATCH;
            ST_LATCH:    state_next = ST_CHAN;
            ST_CHAN:     state_next = ST_DIV;
            ST_DIV:      if (sts.div_done) state_next = ST_STORE;
            ST_STORE:    state_next = sts.last_chan ? ST_WAIT : ST_CHAN;
            ST_WAIT:     if (!sts.out_busy) state_next = ST_EMIT;
            ST_EMIT:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load_table = in_valid && in_action == ACT_LOAD;
                cmd.start_mod = in_valid && in_action == ACT_TICK;
            end
            ST_DISPATCH: begin
                cmd.clear_search = 1'b1;
                cmd.fetch_manual = sts.manual;
            end
            ST_SEARCH: cmd.step_search = 1'b1;
            ST_FETCH:  cmd.fetch_seg = 1'b1;
            ST_LATCH:  cmd.latch_seg = 1'b1;
            ST_CHAN:   cmd.prep_chan = 1'b1;
            ST_STORE:  cmd.store_chan = 1'b1;
            ST_EMIT:   cmd.out_load = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/kcl_datapath.sv
`default_nettype none
module kcl_datapath #(
    parameter int TABLE_DEPTH = kcl_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [15:0]      cfg_data,
    input  wire logic [3:0]       in_entry,
    input  wire logic [31:0]      in_frame,
    input  wire logic [31:0]      in_prim,
    input  wire logic [7:0]       in_lod,
    input  wire logic [31:0]      in_env,
    input  wire kcl_pkg::cmd_t    cmd,
    output kcl_pkg::status_t      sts,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [71:0]           out_chan,
    output logic                  out_err
);
    import kcl_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int KW = $clog2(TABLE_DEPTH + 1);

    logic        mode_reg;
    logic [15:0] loop_reg;
    logic [4:0]  keys_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
            loop_reg <= 16'd1;
            keys_reg <= 5'd2;
        end else if (cfg_we) begin
            if (cfg_index == CFG_MODE) mode_reg <= cfg_data[0];
            if (cfg_index == CFG_LOOP) loop_reg <= cfg_data;
            if (cfg_index == CFG_KEYS) keys_reg <= cfg_data[4:0];
        end
    end

    // Table memory: one write port, one registered read port.
    logic [87:0] mem [TABLE_DEPTH];
    logic [IW-1:0] rd_addr;
    logic [87:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_table && 32'(in_entry) < TABLE_DEPTH) begin
            mem[IW'(in_entry)] <= {in_frame[15:0], in_prim, in_lod, in_env};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Restoring modulo, one quotient bit per cycle.
    logic [32:0] rem_reg;
    logic [31:0] dvd_reg;
    logic [5:0]  mcnt_reg;
    logic        mbusy_reg;
    logic [16:0] len;
    logic [32:0] rem_sh;
    assign len = (loop_reg == 16'd0) ? 17'h10000 : {1'b0, loop_reg};
    assign rem_sh = {rem_reg[31:0], dvd_reg[31]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbusy_reg <= 1'b0;
            mcnt_reg <= '0;
        end else if (cmd.start_mod) begin
            mbusy_reg <= 1'b1;
            mcnt_reg <= '0;
        end else if (mbusy_reg) begin
            mcnt_reg <= mcnt_reg + 6'd1;
            if (mcnt_reg == 6'd31) mbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_mod) begin
            rem_reg <= '0;
            dvd_reg <= in_frame;
        end else if (mbusy_reg) begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= (rem_sh >= {16'd0, len}) ? rem_sh - {16'd0, len} : rem_sh;
        end
    end

    logic [16:0] frame;
    assign frame = rem_reg[16:0];

    // Keyframe search, one entry at a time, each read before it is compared.
    logic [KW-1:0] k_eff;
    logic [KW-1:0] srch_reg;
    logic          sfound_reg;
    logic          sphase_reg;
    logic          past_reg;
    logic [IW-1:0] seg_reg;

    always_comb begin
        if (keys_reg < 5'd2) k_eff = KW'(2);
        else if (32'(keys_reg) > TABLE_DEPTH) k_eff = KW'(TABLE_DEPTH);
        else k_eff = KW'(keys_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_search) begin
            srch_reg <= KW'(1);
            sphase_reg <= 1'b0;
            sfound_reg <= 1'b0;
            past_reg <= 1'b0;
        end else if (cmd.step_search) begin
            if (!sphase_reg) begin
                sphase_reg <= 1'b1;
            end else begin
                sphase_reg <= 1'b0;
                if (frame < {1'b0, rd_data_reg[87:72]}) begin
                    sfound_reg <= 1'b1;
                    seg_reg <= srch_reg[IW-1:0];
                end else if (srch_reg + KW'(1) >= k_eff) begin
                    sfound_reg <= 1'b1;
                    past_reg <= 1'b1;
                    seg_reg <= IW'(k_eff - KW'(1));
                end else begin
                    srch_reg <= srch_reg + KW'(1);
                end
            end
        end
    end

    // Read address: manual lookup; else search walk, earlier segment entry, then the later.
    logic          manual_reg;
    logic          err_reg;
    logic [1:0]    fsel_reg;
    always_comb begin
        rd_addr = srch_reg[IW-1:0];
        if (cmd.fetch_manual) rd_addr = IW'(frame);
        else if (cmd.fetch_seg) rd_addr = past_reg ? seg_reg : seg_reg - IW'(1);
        else if (cmd.latch_seg) rd_addr = seg_reg;
    end

    logic [71:0] lo_reg, hi_reg;
    logic        hold_reg;
    logic signed [17:0] a_reg;
    logic [15:0] lo_start_reg;
    logic [15:0] hi_start_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clear_search) begin
            manual_reg <= !mode_reg;
            err_reg <= !mode_reg && 32'(frame) >= TABLE_DEPTH;
            fsel_reg <= cmd.fetch_manual ? 2'd1 : 2'd0;
        end
        if (cmd.fetch_seg) fsel_reg <= 2'd1;
        if (cmd.latch_seg) begin
            lo_reg <= rd_data_reg[71:0];
            hold_reg <= manual_reg || past_reg;
            a_reg <= $signed({1'b0, frame}) - $signed({2'b0, rd_data_reg[87:72]});
        end
        if (cmd.prep_chan && fsel_reg == 2'd1) begin
            hi_reg <= rd_data_reg[71:0];
            fsel_reg <= 2'd2;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_seg) lo_start_reg <= rd_data_reg[87:72];
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep_chan && fsel_reg == 2'd1) hi_start_reg <= rd_data_reg[87:72];
    end

    // Channel loop with a shared signed divider.
    // The first channel is formed while the later entry is still in the read register.
    logic [3:0] ch_reg;
    logic [7:0] lo_c, hi_c;
    always_comb begin
        lo_c = lo_reg[8*(8-ch_reg) +: 8];
        hi_c = (fsel_reg == 2'd1) ? rd_data_reg[8*(8-ch_reg) +: 8]
                                  : hi_reg[8*(8-ch_reg) +: 8];
    end

    logic signed [17:0] bseg;
    assign bseg = $signed({2'b0, hi_start_reg}) - $signed({2'b0, lo_start_reg});

    logic signed [27:0] prod_reg;
    logic               neg_reg;
    logic [26:0]        num_reg;
    logic [26:0]        q_reg;
    logic [27:0]        r_reg;
    logic [17:0]        den_reg;
    logic [4:0]         dcnt_reg;
    logic               dbusy_reg;
    logic               dphase_reg;
    logic [27:0]        r_sh;
    assign r_sh = {r_reg[26:0], num_reg[26]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            dphase_reg <= 1'b0;
        end else if (cmd.prep_chan) begin
            dphase_reg <= 1'b1;
        end else if (dphase_reg) begin
            dphase_reg <= 1'b0;
            dbusy_reg <= 1'b1;
        end else if (dbusy_reg && dcnt_reg == 5'd26) begin
            dbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep_chan) begin
            prod_reg <= 28'(a_reg * $signed({1'b0, hi_c} - {1'b0, lo_c}));
        end else if (dphase_reg) begin
            neg_reg <= prod_reg[27] ^ bseg[17];
            num_reg <= prod_reg[27] ? 27'(-prod_reg) : prod_reg[26:0];
            den_reg <= bseg[17] ? 18'(-bseg) : 18'(bseg);
            r_reg <= '0;
            q_reg <= '0;
            dcnt_reg <= '0;
        end else if (dbusy_reg) begin
            num_reg <= {num_reg[25:0], 1'b0};
            dcnt_reg <= dcnt_reg + 5'd1;
            if (r_sh >= {10'd0, den_reg}) begin
                r_reg <= r_sh - {10'd0, den_reg};
                q_reg <= {q_reg[25:0], 1'b1};
            end else begin
                r_reg <= r_sh;
                q_reg <= {q_reg[25:0], 1'b0};
            end
        end
    end

    logic [71:0] acc_reg;
    logic [7:0]  qv;
    always_comb begin
        qv = neg_reg ? 8'(-q_reg[7:0]) : q_reg[7:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_seg) ch_reg <= '0;
        else if (cmd.store_chan) begin
            acc_reg[8*(8-ch_reg) +: 8] <= (hold_reg || bseg <= 0) ? lo_c : lo_c + qv;
            ch_reg <= ch_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid <= 1'b0;
        else if (cmd.out_load) out_valid <= 1'b1;
        else if (out_ready) out_valid <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_chan <= err_reg ? 72'd0 : acc_reg;
            out_err <= err_reg;
        end
    end

    assign sts.mod_done = !mbusy_reg && !cmd.start_mod;
    assign sts.manual = !mode_reg;
    assign sts.search_done = sfound_reg;
    assign sts.div_done = !dbusy_reg && !dphase_reg && !cmd.prep_chan;
    assign sts.last_chan = ch_reg == 4'd8;
    assign sts.out_busy = out_valid && !out_ready;
endmodule
`default_nettype wire

FILE: tb/sv/tb_keyframe_color_lerp.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_keyframe_color_lerp;
    import kcl_pkg::*;

    localparam int  DEPTH        = TABLE_DEPTH_DEF;
    localparam int  SETTLE       = 400;
    localparam int  HOLD_CYCLES  = 3000;
    localparam int  STALL_LIMIT  = 20000;
    localparam int  ITEM_TARGET  = 1600;
    localparam logic MODE_MANUAL = 1'b0;
    localparam logic MODE_LINEAR = 1'b1;

    typedef struct packed {
        logic [8:0][7:0] chan;
        logic            err;
    } color_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_MODE;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = ACT_LOAD;
    logic [3:0]  s_entry_index = '0;
    logic [31:0] s_frame_value = '0;
    logic [31:0] s_prim_rgba = '0;
    logic [7:0]  s_prim_lod = '0;
    logic [31:0] s_env_rgba = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_prim_red, m_prim_green, m_prim_blue, m_prim_alpha, m_prim_level;
    logic [7:0]  m_env_red, m_env_green, m_env_blue, m_env_alpha;
    logic        m_index_error;

    keyframe_color_lerp dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_entry_index(s_entry_index), .s_frame_value(s_frame_value),
        .s_prim_rgba(s_prim_rgba), .s_prim_lod(s_prim_lod), .s_env_rgba(s_env_rgba),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_prim_red(m_prim_red), .m_prim_green(m_prim_green), .m_prim_blue(m_prim_blue),
        .m_prim_alpha(m_prim_alpha), .m_prim_level(m_prim_level),
        .m_env_red(m_env_red), .m_env_green(m_env_green), .m_env_blue(m_env_blue),
        .m_env_alpha(m_env_alpha), .m_index_error(m_index_error)
    );

    // Shadow copy of the block's configuration and key table.
    logic        mode_q;
    logic [15:0] loop_q;
    logic [4:0]  keys_q;
    logic [15:0] key_time [DEPTH];
    logic [39:0] prim_mem [DEPTH];
    logic [31:0] env_mem  [DEPTH];

    color_t color_q [$];
    int     fail_count = 0;
    int     items_sent = 0;
    int     stall_count = 0;
    bit     no_idle = 1'b0;
    bit     hold_req = 1'b0;
    int     hold_count = 0;

    always #5 aclk = ~aclk;

    function automatic logic [7:0] chan_of(int e, int c);
        if (c < 5) return prim_mem[e][39 - 8 * c -: 8];
        return env_mem[e][31 - 8 * (c - 5) -: 8];
    endfunction

    function automatic color_t blend_colors(logic [31:0] tick_frame);
        color_t      r;
        logic [31:0] len;
        logic [31:0] frame;
        int          k, i, c, start, stop, ofs, span, lo, hi, v;
        r = '0;
        len = (loop_q == 0) ? 32'd65536 : {16'd0, loop_q};
        frame = tick_frame % len;
        if (mode_q == MODE_MANUAL) begin
            if (frame >= DEPTH) begin
                r.err = 1'b1;
            end else begin
                for (c = 0; c < 9; c++) r.chan[8 - c] = chan_of(frame, c);
            end
            return r;
        end
        k = keys_q;
        if (k < 2) k = 2;
        if (k > DEPTH) k = DEPTH;
        for (i = 1; i < k; i++) begin
            if (frame < key_time[i]) break;
        end
        if (i >= k) begin
            for (c = 0; c < 9; c++) r.chan[8 - c] = chan_of(k - 1, c);
            return r;
        end
        start = key_time[i - 1];
        stop = key_time[i];
        ofs = int'(frame) - start;
        span = stop - start;
        for (c = 0; c < 9; c++) begin
            lo = chan_of(i - 1, c);
            hi = chan_of(i, c);
            v = lo;
            // A negative offset (frame before the segment start) is used as is.
            if (span > 0) v = lo + (ofs * (hi - lo)) / span;
            r.chan[8 - c] = v[7:0];
        end
        return r;
    endfunction

    task automatic send_item(input logic act, input logic [3:0] idx, input logic [31:0] fv,
                             input logic [31:0] prgba, input logic [7:0] lod,
                             input logic [31:0] ergba);
        if (!no_idle && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_entry_index <= idx;
        s_frame_value <= fv;
        s_prim_rgba <= prgba;
        s_prim_lod <= lod;
        s_env_rgba <= ergba;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (act == ACT_LOAD) begin
            key_time[idx] = fv[15:0];
            prim_mem[idx] = {prgba, lod};
            env_mem[idx] = ergba;
        end else begin
            color_q.push_back(blend_colors(fv));
        end
    endtask

    task automatic load_entry(input int idx, input logic [31:0] fv);
        send_item(ACT_LOAD, 4'(idx), fv, $urandom, 8'($urandom), $urandom);
    endtask

    task automatic tick(input logic [31:0] fv);
        send_item(ACT_TICK, 4'($urandom), fv, $urandom, 8'($urandom), $urandom);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (color_q.size() != 0) @(posedge aclk);
    endtask

    // Registers change only when the block is idle.
    task automatic set_config(input logic mode, input logic [15:0] loop_len,
                              input logic [4:0] keys);
        drain_results();
        repeat (SETTLE) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_data <= {15'd0, mode};
        @(posedge aclk);
        cfg_index <= CFG_LOOP;
        cfg_data <= loop_len;
        @(posedge aclk);
        cfg_index <= CFG_KEYS;
        cfg_data <= {11'd0, keys};
        @(posedge aclk);
        cfg_we <= 1'b0;
        mode_q = mode;
        loop_q = loop_len;
        keys_q = keys;
    endtask

    task automatic test_defaults();
        int i;
        // Entries alternate their primary and environment colors between all-zero and all-one.
        // Entry 5 repeats entry 4's time and entry 9 steps backward.
        for (i = 0; i < DEPTH; i++) begin
            send_item(ACT_LOAD, 4'(i),
                      (i == 5) ? 32'hFFFF_0190 : (i == 9) ? 32'd100 : 32'(i * 100),
                      (i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000,
                      (i % 2) ? 8'hFF : 8'h00,
                      (i % 2) ? 32'h0000_0000 : 32'hFFFF_FFFF);
        end
        tick(32'h0000_0000);
        tick(32'hFFFF_FFFF);
    endtask

    task automatic test_manual();
        set_config(MODE_MANUAL, 16'd20, 5'd2);
        tick(32'd0);
        tick(32'd15);
        tick(32'd16);
        tick(32'd39);
        set_config(MODE_MANUAL, 16'd0, 5'd2);
        tick(32'hFFFF_0007);
    endtask

    task automatic test_linear();
        set_config(MODE_LINEAR, 16'd0, 5'd16);
        tick(32'd150);
        tick(32'd400);
        tick(32'd850);
        tick(32'hFFFF_FFFF);
        set_config(MODE_LINEAR, 16'd65535, 5'd31);
        tick(32'd920);
        set_config(MODE_LINEAR, 16'd1000, 5'd1);
        tick(32'd1050);
    endtask

    task automatic test_backpressure();
        int i;
        set_config(MODE_LINEAR, 16'd0, 5'd8);
        hold_req = 1'b1;
        for (i = 0; i < 6; i++) tick($urandom);
        drain_results();
    endtask

    task automatic test_random();
        int          phase, i, n, k, span;
        logic [15:0] loop_len;
        logic [31:0] len, t;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(5))
                0: loop_len = 16'd0;
                1: loop_len = 16'd65535;
                2: loop_len = 16'($urandom_range(1, 40));
                3: loop_len = 16'($urandom);
                default: loop_len = 16'($urandom_range(2, 600));
            endcase
            set_config($urandom_range(3) != 0, loop_len, 5'($urandom));
            no_idle = (phase == 3);
            len = (loop_len == 0) ? 32'd65536 : {16'd0, loop_len};
            k = $urandom_range(2, DEPTH);
            if ($urandom_range(3) != 0) begin
                // Keys ascending across the loop, with an occasional repeated time.
                span = int'(len) / k + 1;
                t = 0;
                for (i = 0; i < k; i++) begin
                    load_entry(i, {16'($urandom_range(65535)), t[15:0]});
                    t = t + $urandom_range(0, span);
                end
            end else begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++) load_entry(int'($urandom_range(DEPTH - 1)), $urandom);
            end
            n = $urandom_range(20, 60);
            for (i = 0; i < n; i++) begin
                if ($urandom_range(9) == 0) load_entry(int'($urandom_range(DEPTH - 1)), $urandom);
                else if ($urandom_range(1)) tick($urandom);
                else tick($urandom_range(0, len - 1));
            end
            phase++;
        end
        no_idle = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (hold_req) begin
            m_ready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES) begin
                hold_req = 1'b0;
                hold_count = 0;
            end
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 8);
        end
    end

    always @(posedge aclk) begin
        color_t got, want;
        int     c;
        if (aresetn && m_valid && m_ready) begin
            got.chan = {m_prim_red, m_prim_green, m_prim_blue, m_prim_alpha, m_prim_level,
                        m_env_red, m_env_green, m_env_blue, m_env_alpha};
            got.err = m_index_error;
            if (color_q.size() == 0) begin
                $display("%0t: unexpected result transaction %h", $time, got);
                fail_count++;
            end else begin
                want = color_q.pop_front();
                for (c = 0; c < 9; c++) begin
                    if (got.chan[8 - c] !== want.chan[8 - c]) begin
                        $display("%0t: channel %0d expected %h actual %h",
                                 $time, c, want.chan[8 - c], got.chan[8 - c]);
                        fail_count++;
                    end
                end
                if (got.err !== want.err) begin
                    $display("%0t: index_error expected %b actual %b",
                             $time, want.err, got.err);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_count <= 0;
        else stall_count <= stall_count + 1;
        if (stall_count == STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        mode_q = MODE_LINEAR;
        loop_q = 16'd1;
        keys_q = 5'd2;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults();
        test_manual();
        test_linear();
        test_backpressure();
        test_random();
        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
